// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the haversine distance RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that an implication holds on every clock edge outside reset
`define ASSERT_IMPL(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// check that a condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_s, rst_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

`endif

// ===== rtl/hav_pkg.sv =====
// Package for the haversine distance unit: widths, constants, arctangent table.
// No dependencies.
`default_nettype none
package hav_pkg;
    localparam int LatW = 30;
    localparam int LonW = 31;
    localparam int RadW = 23;
    localparam int DistW = 29;
    localparam logic signed [36:0] TurnUnits = 37'sd3019898880;
    localparam logic signed [36:0] HalfUnits = 37'sd1509949440;
    localparam logic signed [36:0] QuartUnits = 37'sd754974720;
    localparam logic [26:0] DegToRad = 27'd74961321;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
    localparam logic [DistW-1:0] DistMax = '1;
    localparam logic [0:0] RegRadius = 1'b0;

    function automatic logic signed [33:0] atan_tab(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sd843314856;
            1: t = 34'sd497837829;
            2: t = 34'sd263043836;
            3: t = 34'sd133525158;
            4: t = 34'sd67021686;
            5: t = 34'sd33543515;
            6: t = 34'sd16775850;
            7: t = 34'sd8388437;
            8: t = 34'sd4194282;
            9: t = 34'sd2097149;
            10: t = 34'sd1048575;
            11: t = 34'sd524287;
            12: t = 34'sd262143;
            13: t = 34'sd131071;
            14: t = 34'sd65535;
            15: t = 34'sd32767;
            16: t = 34'sd16383;
            17: t = 34'sd8191;
            18: t = 34'sd4095;
            19: t = 34'sd2047;
            20: t = 34'sd1023;
            21: t = 34'sd511;
            22: t = 34'sd255;
            23: t = 34'sd127;
            24: t = 34'sd63;
            25: t = 34'sd31;
            26: t = 34'sd15;
            27: t = 34'sd7;
            28: t = 34'sd3;
            29: t = 34'sd1;
            default: t = 34'sd0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/hav_sincos.sv =====
// Pipelined sine/cosine: angle wrap, fold, radian scaling, rotation CORDIC.
// Depends on hav_pkg. Advances when en is high.
`default_nettype none
module hav_sincos #(
    parameter int ITER = 24
) (
    input  wire                       clk,
    input  wire                       en,
    input  wire logic signed [33:0]   angle,
    output logic signed [33:0]        sin_q,
    output logic signed [33:0]        cos_q
);
    import hav_pkg::*;

    logic signed [36:0] r_next;
    logic               ncos_next, ncos_reg;
    logic               neg_reg;
    logic        [29:0] mag_reg;
    logic signed [36:0] a_ext, mod_t, w;
    logic        [56:0] prod;
    logic signed [33:0] z0;
    logic signed [33:0] x_reg [0:ITER];
    logic signed [33:0] y_reg [0:ITER];
    logic signed [33:0] z_reg [0:ITER];
    logic               nc_reg [0:ITER];

    // the angle magnitude stays below one turn, so one add wraps it
    always_comb
    begin
        a_ext = 37'(angle);
        mod_t = a_ext;
        if (mod_t < 0)
            mod_t = mod_t + TurnUnits;
        if (mod_t >= HalfUnits)
            mod_t = mod_t - TurnUnits;
        w = mod_t;
        ncos_next = 1'b0;
        if (w > QuartUnits)
        begin
            w = HalfUnits - w;
            ncos_next = 1'b1;
        end
        else if (w < -QuartUnits)
        begin
            w = -HalfUnits - w;
            ncos_next = 1'b1;
        end
        r_next = w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ncos_reg <= ncos_next;
            neg_reg  <= r_next < 0;
            mag_reg  <= (r_next < 0) ? 30'(-r_next) : 30'(r_next);
        end
    end

    assign prod = 57'(mag_reg) * 57'(DegToRad) + 57'(1 << 24);
    assign z0 = neg_reg ? -34'(prod >> 25) : 34'(prod >> 25);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= CordicGain;
            y_reg[0]  <= '0;
            z_reg[0]  <= z0;
            nc_reg[0] <= ncos_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < ITER; i++)
        begin : g_stage
            localparam int Sh = (i < 32) ? i : 31;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nc_reg[i+1] <= nc_reg[i];
                    if (i >= 32)
                    begin
                        x_reg[i+1] <= x_reg[i];
                        y_reg[i+1] <= y_reg[i];
                        z_reg[i+1] <= z_reg[i];
                    end
                    else if (z_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> Sh);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> Sh);
                        z_reg[i+1] <= z_reg[i] - atan_tab(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> Sh);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> Sh);
                        z_reg[i+1] <= z_reg[i] + atan_tab(i);
                    end
                end
            end
        end
    endgenerate

    logic signed [33:0] xf;
    assign xf = nc_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
    assign sin_q = (y_reg[ITER] > OneQ30) ? OneQ30 :
                   (y_reg[ITER] < -OneQ30) ? -OneQ30 : y_reg[ITER];
    assign cos_q = (xf > OneQ30) ? OneQ30 : (xf < -OneQ30) ? -OneQ30 : xf;
endmodule
`default_nettype wire

// ===== rtl/hav_sqrt_atan.sv =====
// Pipelined floor square roots of a and 1-a, then vectoring CORDIC atan2.
// Depends on hav_pkg. Advances when en is high.
`default_nettype none
module hav_sqrt_atan #(
    parameter int ITER = 24
) (
    input  wire                clk,
    input  wire                en,
    input  wire logic [30:0]   a_q,
    output logic signed [33:0] half
);
    import hav_pkg::*;

    localparam int SqS = 31;

    logic [61:0] va_reg [0:SqS];
    logic [61:0] vb_reg [0:SqS];
    logic [61:0] ra_reg [0:SqS];
    logic [61:0] rb_reg [0:SqS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg[0] <= 62'(a_q) << 30;
            vb_reg[0] <= 62'(31'(OneQ30) - a_q) << 30;
            ra_reg[0] <= '0;
            rb_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SqS; k++)
        begin : g_sq
            localparam int Bp = 2 * (SqS - 1 - k);
            logic [62:0] ta, tb;
            assign ta = 63'(ra_reg[k]) + (63'(1) << Bp);
            assign tb = 63'(rb_reg[k]) + (63'(1) << Bp);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (63'(va_reg[k]) >= ta)
                    begin
                        va_reg[k+1] <= 62'(63'(va_reg[k]) - ta);
                        ra_reg[k+1] <= (ra_reg[k] >> 1) + (62'(1) << Bp);
                    end
                    else
                    begin
                        va_reg[k+1] <= va_reg[k];
                        ra_reg[k+1] <= ra_reg[k] >> 1;
                    end
                    if (63'(vb_reg[k]) >= tb)
                    begin
                        vb_reg[k+1] <= 62'(63'(vb_reg[k]) - tb);
                        rb_reg[k+1] <= (rb_reg[k] >> 1) + (62'(1) << Bp);
                    end
                    else
                    begin
                        vb_reg[k+1] <= vb_reg[k];
                        rb_reg[k+1] <= rb_reg[k] >> 1;
                    end
                end
            end
        end
    endgenerate

    logic signed [34:0] x_reg [0:ITER];
    logic signed [34:0] y_reg [0:ITER];
    logic signed [34:0] z_reg [0:ITER];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= 35'(rb_reg[SqS]);
            y_reg[0] <= 35'(ra_reg[SqS]);
            z_reg[0] <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < ITER; i++)
        begin : g_vec
            localparam int Sh = (i < 32) ? i : 31;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (i >= 32)
                    begin
                        x_reg[i+1] <= x_reg[i];
                        y_reg[i+1] <= y_reg[i];
                        z_reg[i+1] <= z_reg[i];
                    end
                    else if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> Sh);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> Sh);
                        z_reg[i+1] <= z_reg[i] + 35'(atan_tab(i));
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> Sh);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> Sh);
                        z_reg[i+1] <= z_reg[i] - 35'(atan_tab(i));
                    end
                end
            end
        end
    endgenerate

    assign half = (z_reg[ITER] < 0) ? '0 : 34'(z_reg[ITER]);
endmodule
`default_nettype wire

// ===== rtl/haversine_distance_unit.sv =====
// Haversine great-circle distance unit, top level.
// Depends on hav_pkg, hav_sincos, hav_sqrt_atan, assert_macros.svh.
//
//  channel | dir | fields
//  s_axis  | in  | first_latitude, first_longitude, second_latitude, second_longitude
//  m_axis  | out | distance
//  apb     | in  | earth_radius_m at 0x0
//
// One request per cycle unless the output stalls; a result goes through the two CORDIC chains
// and the 31-step square-root pipeline before it reaches the output register.
// The whole pipeline stalls when the output register is full and not taken.
// Reset clears valid bits and loads the radius with 6371000.
`default_nettype none
module haversine_distance_unit #(
    parameter int ANGLE_ITERATIONS = 24
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [29:0] first_latitude, [60:30] first_longitude,
    // [90:61] second_latitude, [121:91] second_longitude
    input  wire  [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [28:0] distance
    output logic [31:0]  m_axis_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [0:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hav_pkg::*;
    `include "assert_macros.svh"

    localparam int SCL = ANGLE_ITERATIONS + 2;
    localparam int LAT = SCL + 5 + 33 + ANGLE_ITERATIONS + 1;

    logic [RadW-1:0] radius_reg;
    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic            out_vld_reg;
    logic [DistW-1:0] out_reg;

    assign pready = 1'b1;
    assign prdata = 32'(radius_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 23'd6371000;
        else if (psel && penable && pwrite && paddr == RegRadius)
            radius_reg <= pwdata[RadW-1:0];
    end

    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [LatW-1:0] lat1, lat2;
    logic signed [LonW-1:0] lon1, lon2;
    assign lat1 = s_axis_tdata[29:0];
    assign lon1 = s_axis_tdata[60:30];
    assign lat2 = s_axis_tdata[90:61];
    assign lon2 = s_axis_tdata[121:91];

    logic signed [33:0] s1, c1, s2, c2, sa, ca, sb, cb;
    hav_sincos #(.ITER(ANGLE_ITERATIONS)) u_dlat (.clk(clk), .en(en),
        .angle(34'(lat2) - 34'(lat1)), .sin_q(s1), .cos_q(c1));
    hav_sincos #(.ITER(ANGLE_ITERATIONS)) u_dlon (.clk(clk), .en(en),
        .angle(34'(lon2) - 34'(lon1)), .sin_q(s2), .cos_q(c2));
    hav_sincos #(.ITER(ANGLE_ITERATIONS)) u_lat1 (.clk(clk), .en(en),
        .angle(34'(lat1) <<< 1), .sin_q(sa), .cos_q(ca));
    hav_sincos #(.ITER(ANGLE_ITERATIONS)) u_lat2 (.clk(clk), .en(en),
        .angle(34'(lat2) <<< 1), .sin_q(sb), .cos_q(cb));

    logic signed [33:0] s1sq_reg, s2sq_reg, p_reg, s1sq_b_reg, s2sq_b_reg, q_reg;
    logic signed [33:0] s1sq_c_reg, a_reg, p_b_reg;
    logic signed [67:0] m1, m2, m3, m4;
    logic [30:0] a_cl_reg;
    assign m1 = 68'(s1) * 68'(s1);
    assign m2 = 68'(s2) * 68'(s2);
    assign m3 = 68'(ca) * 68'(cb);
    assign m4 = 68'(p_b_reg) * 68'(s2sq_b_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1sq_reg   <= 34'(m1 >>> 30);
            s2sq_reg   <= 34'(m2 >>> 30);
            p_reg      <= 34'(m3 >>> 30);
            s1sq_b_reg <= s1sq_reg;
            s2sq_b_reg <= s2sq_reg;
            p_b_reg    <= p_reg;
            q_reg      <= 34'(m4 >>> 30);
            s1sq_c_reg <= s1sq_b_reg;
            a_reg      <= s1sq_c_reg + q_reg;
            a_cl_reg   <= (a_reg < 0) ? '0 : (a_reg > OneQ30) ? 31'(OneQ30) : 31'(a_reg);
        end
    end

    logic signed [33:0] half;
    hav_sqrt_atan #(.ITER(ANGLE_ITERATIONS)) u_sa (.clk(clk), .en(en),
        .a_q(a_cl_reg), .half(half));

    logic [56:0] d_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= (57'(radius_reg) * 57'(half) + 57'(1 << 24)) >> 25;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= (d_reg > 57'(DistMax)) ? DistMax : d_reg[DistW-1:0];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = 32'(out_reg);

    `ASSERT_IMPL(a_stall_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (vld_reg == $past(vld_reg)),
        "pipeline moved during stall")
    `ASSERT_ALWAYS(a_ready, clk, rst_n, m_axis_tvalid || s_axis_tready,
        "not ready with empty output")
    `ASSERT_IMPL(a_out, clk, rst_n,
        (en && vld_reg[LAT-1]) |=> m_axis_tvalid, "result lost")
endmodule
`default_nettype wire

// ===== sim/tb_haversine_distance_unit.sv =====
// Self-checking testbench for haversine_distance_unit: random and directed point pairs,
// radius register writes over APB, with an in-bench fixed-point predictor.
// Depends on hav_pkg and the haversine_distance_unit RTL.
`default_nettype none
module tb_haversine_distance_unit;
    import hav_pkg::*;

    localparam int  Iters = 24;
    localparam int  WatchdogLimit = 5000;
    localparam int  DrainCycles = 2 * Iters + 60;
    localparam longint TurnU = 64'sd3019898880;
    localparam longint HalfU = 1509949440;
    localparam longint QuartU = 754974720;
    localparam longint RadScale = 74961321;
    localparam longint GainQ30 = 652032874;
    localparam longint UnitQ30 = 64'sd1073741824;
    localparam logic [0:0] BadAddr = 1'b1;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;  // lat1, lon1, lat2, lon2 from bit 0 up
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;   // distance
    logic psel;
    logic penable;
    logic pwrite;
    logic [0:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic [127:0] pending_reqs[$];
    logic [DistW-1:0] expected_dist[$];
    logic [RadW-1:0] radius_m;
    logic req_taken;
    logic dist_taken;
    logic no_idle;
    int gap_cnt;
    int stall_cnt;
    int errors;
    int idle_cycles;

    haversine_distance_unit #(.ANGLE_ITERATIONS(Iters)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint atan_step(input int i);
        longint t[32];
        t = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
              16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
              131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
              127, 63, 31, 15, 7, 3, 1, 0, 0};
        return t[i];
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // angle in 2^-23 degree units -> Q30 sine and cosine
    task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
        longint r, mag, z, x, y, dx, dy;
        bit flip_cos;
        r = ang % TurnU;
        flip_cos = 1'b0;
        if (r < 0) r += TurnU;
        if (r >= HalfU) r -= TurnU;
        if (r > QuartU)
        begin
            r = HalfU - r;
            flip_cos = 1'b1;
        end
        else if (r < -QuartU)
        begin
            r = -HalfU - r;
            flip_cos = 1'b1;
        end
        mag = r < 0 ? -r : r;
        mag = (mag * RadScale + (64'sd1 << 24)) >>> 25;
        z = r < 0 ? -mag : mag;
        x = GainQ30;
        y = 0;
        for (int i = 0; i < Iters && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip_cos) x = -x;
        sn = clip(y, -UnitQ30, UnitQ30);
        cs = clip(x, -UnitQ30, UnitQ30);
    endtask

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint half_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < Iters && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z < 0 ? 0 : z;
    endfunction

    task automatic predict_distance(input logic [127:0] req,
                                    output logic [DistW-1:0] dist_out);
        longint lat1, lon1, lat2, lon2;
        longint s1, c1, s2, c2, sa, cl1, sb, cl2, p, a, h;
        longint unsigned d;
        lat1 = longint'($signed(req[29:0]));
        lon1 = longint'($signed(req[60:30]));
        lat2 = longint'($signed(req[90:61]));
        lon2 = longint'($signed(req[121:91]));
        rotate_angle(lat2 - lat1, s1, c1);
        rotate_angle(lon2 - lon1, s2, c2);
        rotate_angle(lat1 * 2, sa, cl1);
        rotate_angle(lat2 * 2, sb, cl2);
        p = (cl1 * cl2) >>> 30;
        a = ((s1 * s1) >>> 30) + ((p * ((s2 * s2) >>> 30)) >>> 30);
        a = clip(a, 0, UnitQ30);
        h = half_angle(floor_sqrt(longint'(a) << 30), floor_sqrt((UnitQ30 - a) << 30));
        d = (longint'(radius_m) * h + (64'd1 << 24)) >> 25;
        if (d > 64'(DistMax)) d = 64'(DistMax);
        dist_out = d[DistW-1:0];
    endtask

    function automatic logic [127:0] pack_req(input logic [29:0] la1, input logic [30:0] lo1,
                                              input logic [29:0] la2, input logic [30:0] lo2);
        return {6'b0, lo2, la2, lo1, la1};
    endfunction

    function automatic logic [29:0] rand_lat();
        return 30'($signed($urandom_range(0, 754974720)) - 377487360);
    endfunction

    function automatic logic [30:0] rand_lon();
        return 31'(longint'($urandom_range(0, 1509949440)) - 754974720);
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_reqs.push_back(pack_req(30'($urandom), 31'($urandom),
                                                30'($urandom), 31'($urandom)));
            else if ($urandom_range(0, 4) == 0)
                // random pairs with low bits of the second point flipped
                pending_reqs.push_back(pack_req(rand_lat(), rand_lon(),
                    rand_lat() & 30'h3fff_ffff, rand_lon()) ^ {6'b0, 31'($urandom_range(0, 4095)),
                    30'($urandom_range(0, 4095)), 61'b0});
            else
                pending_reqs.push_back(pack_req(rand_lat(), rand_lon(), rand_lat(), rand_lon()));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_dist.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic apb_write(input logic [0:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == RegRadius) radius_m = value[RadW-1:0];
    endtask

    task automatic report(input logic [DistW-1:0] got, input logic [DistW-1:0] want);
        $display("distance mismatch: got %0d expected %0d", got, want);
        errors++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !req_taken)
            s_axis_tvalid <= 1'b1;
        else if (gap_cnt > 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_cnt <= gap_cnt - 1;
        end
        else if (pending_reqs.size() != 0)
        begin
            s_axis_tdata <= pending_reqs.pop_front();
            s_axis_tvalid <= 1'b1;
            gap_cnt <= no_idle ? 0 : $urandom_range(0, 3);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // result side stall control
    always @(negedge clk)
    begin
        if (dist_taken && !no_idle && stall_cnt == 0)
            stall_cnt <= $urandom_range(0, 3);
        if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [DistW-1:0] want;
        req_taken <= s_axis_tvalid && s_axis_tready;
        dist_taken <= m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_distance(s_axis_tdata, want);
            expected_dist.push_back(want);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_dist.size() == 0)
            begin
                $display("unexpected distance result %0d", m_axis_tdata[DistW-1:0]);
                errors++;
            end
            else
            begin
                want = expected_dist.pop_front();
                if (m_axis_tdata[DistW-1:0] !== want) report(m_axis_tdata[DistW-1:0], want);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_taken = 1'b0;
        dist_taken = 1'b0;
        no_idle = 1'b0;
        gap_cnt = 0;
        stall_cnt = 0;
        errors = 0;
        idle_cycles = 0;
        radius_m = 23'd6371000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: same point, antipodes, poles, range edges, raw bit patterns
        pending_reqs.push_back(pack_req(0, 0, 0, 0));
        pending_reqs.push_back(pack_req(0, 0, 0, 31'd754974720));
        pending_reqs.push_back(pack_req(0, -31'sd754974720, 0, 31'd754974720));
        pending_reqs.push_back(pack_req(30'd377487360, 0, -30'sd377487360, 0));
        pending_reqs.push_back(pack_req(30'd377487360, 31'd123456, 30'd377487360, -31'sd99));
        pending_reqs.push_back(pack_req(-30'sd377487360, -31'sd754974720,
                                        30'd377487360, 31'd754974720));
        pending_reqs.push_back(pack_req(30'd1, 31'd1, 30'd2, 31'd2));
        pending_reqs.push_back(pack_req(30'd188743680, 31'd377487360, 0, 0));
        pending_reqs.push_back(pack_req('1, '1, '0, '0));
        pending_reqs.push_back(pack_req(30'h1fff_ffff, 31'h3fff_ffff,
                                        30'h2000_0000, 31'h4000_0000));
        pending_reqs.push_back(pack_req(30'h2aaa_aaaa, 31'h5555_5555,
                                        30'h1555_5555, 31'h2aaa_aaaa));
        pending_reqs.push_back(pack_req(0, 0, 30'd377487360, 0));
        queue_random(80);
        wait_drained();

        apb_write(RegRadius, 32'd8388607);
        pending_reqs.push_back(pack_req(0, -31'sd754974720, 0, 31'd754974720));
        queue_random(80);
        wait_drained();

        apb_write(RegRadius, 32'd1);
        queue_random(60);
        wait_drained();

        apb_write(RegRadius, 32'd0);
        queue_random(20);
        wait_drained();

        // unmapped address must not touch the radius
        apb_write(RegRadius, 32'd6371000);
        apb_write(BadAddr, 32'd12345);
        no_idle = 1'b1;
        queue_random(80);
        wait_drained();

        no_idle = 1'b0;
        apb_write(RegRadius, 32'hff00_1234);
        queue_random(80);
        wait_drained();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
